FILE: rtl/swlru_pkg.sv
// Package: shared types and constants for the size-weighted LRU store.
`timescale 1ns / 1ps
`default_nettype none
package swlru_pkg;
    localparam int unsigned Depth = 16;
    localparam int unsigned IdxW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [31:0] CapReset = 32'd1048576;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_TOUCH  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_CHK,
        ST_EVICT,
        ST_SCAN,
        ST_SHIFT,
        ST_PUT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic ptr_clr;
        logic ptr_load;
        logic ptr_inc;
        logic evict;
        logic shift_step;
        logic put_new;
        logic put_saved;
        logic remove_hit;
        logic emit_notice;
        logic emit_status;
        logic set_ok;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    size_fits;
        logic    need_evict;
        logic    scan_end;
        logic    scan_hit;
        logic    shift_end;
    } t_sts;
endpackage
`default_nettype wire

FILE: rtl/swlru_dp.sv
// Datapath: entry memory, byte total, scan pointer and result registers.
`timescale 1ns / 1ps
`default_nettype none
module swlru_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic [1:0]         i_action,
    input  wire logic [31:0]        i_file_ref,
    input  wire logic [31:0]        i_file_size,
    input  wire swlru_pkg::t_cmd    i_cmd,
    output swlru_pkg::t_sts         o_sts,
    output logic                    o_valid,
    output logic                    o_result_kind,
    output logic [31:0]             o_ref_out,
    output logic                    o_success,
    output logic [31:0]             o_used_bytes,
    output logic [31:0]             o_free_bytes,
    output logic                    o_last_result
);
    localparam int unsigned CW = swlru_pkg::CntW;
    localparam int unsigned IW = swlru_pkg::IdxW;

    logic [31:0] r_ref  [swlru_pkg::Depth];
    logic [31:0] r_size [swlru_pkg::Depth];
    logic [31:0] r_cap, r_used, r_req_ref, r_req_size, r_sv_ref, r_sv_size;
    logic [1:0]  r_act;
    logic [CW-1:0] r_cnt, r_ptr;
    logic        r_ok;
    logic [31:0] n_used;
    logic [IW-1:0] last_idx, ptr_idx, ptm1_idx;
    logic [32:0] need;
    logic [31:0] free_n;

    assign last_idx = IW'(r_cnt - CW'(1));
    assign ptr_idx  = r_ptr[IW-1:0];
    assign ptm1_idx = IW'(r_ptr - CW'(1));
    assign need     = {1'b0, r_req_size} + {1'b0, r_used};

    assign o_sts.action     = swlru_pkg::t_action'(r_act);
    assign o_sts.size_fits  = (r_req_size <= r_cap);
    assign o_sts.need_evict = (r_cnt != '0) &&
        ((need > {1'b0, r_cap}) || (r_cnt >= CW'(swlru_pkg::Depth)));
    assign o_sts.scan_end   = (r_ptr >= r_cnt);
    assign o_sts.scan_hit   = (r_ref[ptr_idx] == r_req_ref);
    assign o_sts.shift_end  = (r_ptr == '0);

    always_comb begin
        n_used = r_used;
        if (i_cmd.evict)
            n_used = (r_size[last_idx] > r_used) ? '0 : r_used - r_size[last_idx];
        else if (i_cmd.remove_hit)
            n_used = (r_sv_size > r_used) ? '0 : r_used - r_sv_size;
        else if (i_cmd.put_new)
            n_used = r_used + r_req_size;
    end
    assign free_n = (n_used > r_cap) ? '0 : r_cap - n_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= swlru_pkg::CapReset;
            r_used  <= '0;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_ok    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            r_used  <= n_used;
            o_valid <= i_cmd.emit_notice | i_cmd.emit_status;
            if (i_cmd.load) begin
                r_ok <= 1'b0;
            end else if (i_cmd.set_ok) begin
                r_ok <= 1'b1;
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_load) begin
                r_ptr <= r_cnt;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + CW'(1);
            end else if (i_cmd.shift_step) begin
                r_ptr <= r_ptr - CW'(1);
            end
            if (i_cmd.evict) r_cnt <= r_cnt - CW'(1);
            if (i_cmd.put_new) r_cnt <= r_cnt + CW'(1);
            if (i_cmd.remove_hit) r_cnt <= r_cnt - CW'(1);
        end
    end

    // Entry shifting: shift_step moves slot ptr-1 into slot ptr (toward old end);
    // after a remove hit, ptr_inc moves slot ptr+1 into ptr walking up (remove_hit only updates count and byte total).
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act      <= i_action;
            r_req_ref  <= i_file_ref;
            r_req_size <= i_file_size;
        end
        if (i_cmd.set_ok) begin
            r_sv_ref  <= r_ref[ptr_idx];
            r_sv_size <= r_size[ptr_idx];
        end
        if (i_cmd.shift_step && r_ptr != '0) begin
            r_ref[ptr_idx]  <= r_ref[ptm1_idx];
            r_size[ptr_idx] <= r_size[ptm1_idx];
        end
        if (i_cmd.put_new) begin
            r_ref[0]  <= r_req_ref;
            r_size[0] <= r_req_size;
        end
        if (i_cmd.put_saved) begin
            r_ref[0]  <= r_sv_ref;
            r_size[0] <= r_sv_size;
        end
        if (i_cmd.ptr_inc && r_ok && r_act == swlru_pkg::ACT_REMOVE
                && ptr_idx != IW'(swlru_pkg::Depth - 1)) begin
            r_ref[ptr_idx]  <= r_ref[IW'(r_ptr + CW'(1))];
            r_size[ptr_idx] <= r_size[IW'(r_ptr + CW'(1))];
        end
        o_result_kind <= i_cmd.emit_status;
        o_ref_out     <= i_cmd.emit_status ? r_req_ref : r_ref[last_idx];
        o_success     <= i_cmd.emit_status & r_ok;
        o_last_result <= i_cmd.emit_status;
        o_used_bytes  <= n_used;
        o_free_bytes  <= free_n;
    end
endmodule
`default_nettype wire

FILE: rtl/swlru_ctrl.sv
// Controller: request sequencing state machine.
`timescale 1ns / 1ps
`default_nettype none
module swlru_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire swlru_pkg::t_sts i_sts,
    output swlru_pkg::t_cmd      o_cmd,
    output logic                 o_busy
);
    swlru_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= swlru_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // After a remove hit, ST_SCAN keeps walking to the end to compact the table.
    logic r_hit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (r_state == swlru_pkg::ST_IDLE) begin
            r_hit <= 1'b0;
        end else if (o_cmd.set_ok) begin
            r_hit <= 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swlru_pkg::ST_IDLE:
                if (i_start) n_state = swlru_pkg::ST_ADD_CHK;
            swlru_pkg::ST_ADD_CHK:
                if (i_sts.action != swlru_pkg::ACT_ADD) n_state = swlru_pkg::ST_SCAN;
                else if (!i_sts.size_fits) n_state = swlru_pkg::ST_DONE;
                else if (i_sts.need_evict) n_state = swlru_pkg::ST_EVICT;
                else n_state = swlru_pkg::ST_SHIFT;
            swlru_pkg::ST_EVICT:
                n_state = swlru_pkg::ST_ADD_CHK;
            swlru_pkg::ST_SCAN:
                if (r_hit) begin
                    if (i_sts.scan_end) n_state = swlru_pkg::ST_DONE;
                end else if (i_sts.scan_end) begin
                    n_state = swlru_pkg::ST_DONE;
                end else if (i_sts.scan_hit) begin
                    unique case (i_sts.action)
                        swlru_pkg::ACT_REMOVE: n_state = swlru_pkg::ST_SCAN;
                        swlru_pkg::ACT_TOUCH:  n_state = swlru_pkg::ST_SHIFT;
                        default:               n_state = swlru_pkg::ST_DONE;
                    endcase
                end
            swlru_pkg::ST_SHIFT:
                if (i_sts.shift_end) n_state = swlru_pkg::ST_PUT;
            swlru_pkg::ST_PUT:
                n_state = swlru_pkg::ST_DONE;
            swlru_pkg::ST_DONE:
                n_state = swlru_pkg::ST_IDLE;
            default:
                n_state = swlru_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != swlru_pkg::ST_IDLE);
        unique case (r_state)
            swlru_pkg::ST_IDLE: begin
                o_cmd.load    = i_start;
                o_cmd.ptr_clr = 1'b1;
            end
            swlru_pkg::ST_ADD_CHK: begin
                // prime pointer at count for the insert shift
                o_cmd.ptr_load = (i_sts.action == swlru_pkg::ACT_ADD);
            end
            swlru_pkg::ST_EVICT: begin
                o_cmd.evict       = 1'b1;
                o_cmd.emit_notice = 1'b1;
            end
            swlru_pkg::ST_SCAN: begin
                if (r_hit) begin
                    if (!i_sts.scan_end) o_cmd.ptr_inc = 1'b1;
                end else if (!i_sts.scan_end) begin
                    if (i_sts.scan_hit) begin
                        o_cmd.set_ok     = 1'b1;
                        o_cmd.remove_hit = 1'b0;
                        if (i_sts.action == swlru_pkg::ACT_REMOVE) o_cmd.ptr_clr = 1'b0;
                    end else begin
                        o_cmd.ptr_inc = 1'b1;
                    end
                end
            end
            swlru_pkg::ST_SHIFT: o_cmd.shift_step = 1'b1;
            swlru_pkg::ST_PUT: begin
                if (i_sts.action == swlru_pkg::ACT_ADD) o_cmd.put_new = 1'b1;
                else o_cmd.put_saved = 1'b1;
            end
            swlru_pkg::ST_DONE: begin
                o_cmd.emit_status = 1'b1;
                o_cmd.remove_hit  = r_hit && (i_sts.action == swlru_pkg::ACT_REMOVE);
            end
            default: o_cmd = '0;
        endcase
        if (r_state == swlru_pkg::ST_ADD_CHK && i_sts.action == swlru_pkg::ACT_ADD
                && i_sts.size_fits && !i_sts.need_evict) begin
            o_cmd.set_ok = 1'b1;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/size_weighted_lru_store.sv
// Top level: size-weighted LRU store.
//  channel   | signals                                  | timing
//  request   | i_start, o_busy, i_action/file_ref/size  | taken when i_start & !o_busy
//  config    | i_cfg_we, i_cfg_data                     | written when i_cfg_we
//  result    | o_valid + payload                        | one cycle, no backpressure
// o_busy stays high while an add, remove, find or touch is handled, for a time that
// grows with the one-slot-a-cycle walk of the entry table. Each result item is
// registered before it leaves. Reset is synchronous, active low; it empties the table
// and restores the capacity. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module size_weighted_lru_store (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_file_ref,
    input  wire logic [31:0] i_file_size,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    output logic             o_result_kind,
    output logic [31:0]      o_ref_out,
    output logic             o_success,
    output logic [31:0]      o_used_bytes,
    output logic [31:0]      o_free_bytes,
    output logic             o_last_result
);
    swlru_pkg::t_cmd cmd;
    swlru_pkg::t_sts sts;

    swlru_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_sts(sts), .o_cmd(cmd), .o_busy(o_busy)
    );

    swlru_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_action(i_action), .i_file_ref(i_file_ref), .i_file_size(i_file_size),
        .i_cmd(cmd), .o_sts(sts), .o_valid(o_valid), .o_result_kind(o_result_kind),
        .o_ref_out(o_ref_out), .o_success(o_success), .o_used_bytes(o_used_bytes),
        .o_free_bytes(o_free_bytes), .o_last_result(o_last_result)
    );
endmodule
`default_nettype wire
